// ----- design/swse_pkg.sv -----
package swse_pkg;

  // Request codes carried in the slave-side tuser.
  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_INSPECT = 2'd2;
  // Spare code, handled as an inspect.
  localparam logic [1:0] REQ_SPARE   = 2'd3;

  // Status codes reported with every result.
  localparam logic [1:0] STS_DONE  = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  // Sentinels reported for an empty stack.
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  // Field widths.
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned DEPTH_W = 5;

  // Slave-side tdata layout: value, then key.
  localparam int unsigned IN_DATA_W = 2 * WORD_W;

  // Master-side tdata layout, lowest bit first.
  localparam int unsigned OUT_STS_LSB   = 0;
  localparam int unsigned OUT_FOUND_LSB = OUT_STS_LSB + STS_W;
  localparam int unsigned OUT_LO_LSB    = OUT_FOUND_LSB + 1;
  localparam int unsigned OUT_HI_LSB    = OUT_LO_LSB + WORD_W;
  localparam int unsigned OUT_DEPTH_LSB = OUT_HI_LSB + WORD_W;
  localparam int unsigned OUT_TOP_LSB   = OUT_DEPTH_LSB + DEPTH_W;
  localparam int unsigned OUT_DATA_W    = OUT_TOP_LSB + WORD_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch an accepted request
    logic update;     // apply push or pop, clear the scan results
    logic scan_step;  // read the next stored entry
    logic load_out;   // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;      // no entries held
    logic last;       // scan index points at the top entry
  } stat_t;

endpackage

// ----- design/swse_ctrl.sv -----
module swse_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  swse_pkg::stat_t stat_i,
  output swse_pkg::cmd_t  cmd_o
);
  import swse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_TAIL,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Commands decoded from the current state.
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.update    = (state_q == S_UPDATE);
    cmd_o.scan_step = (state_q == S_SCAN) && !stat_i.empty;
    cmd_o.load_out  = (state_q == S_FINISH) && out_free;
  end

  // State register and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (stat_i.empty) begin
            state_q <= S_FINISH;
          end else if (stat_i.last) begin
            state_q <= S_TAIL;
          end
        end
        S_TAIL: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/swse_dpath.sv -----
module swse_dpath #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  swse_pkg::cmd_t                      cmd_i,
  output swse_pkg::stat_t                     stat_o,
  input  logic [swse_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [swse_pkg::WORD_W-1:0]  value_i,
  input  logic signed [swse_pkg::WORD_W-1:0]  key_i,
  output logic [swse_pkg::OUT_DATA_W-1:0]     out_data_o
);
  import swse_pkg::*;

  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Stack memory, one write and one registered read port.
  logic [WORD_W-1:0] mem_q [STACK_DEPTH];

  logic [REQ_W-1:0]         req_q;
  logic signed [WORD_W-1:0] value_q;
  logic signed [WORD_W-1:0] key_q;
  logic [CNT_W-1:0]         count_q;
  logic [ADDR_W-1:0]        idx_q;
  logic signed [WORD_W-1:0] rd_q;
  logic                     rd_vld_q;
  logic [STS_W-1:0]         status_q;
  logic                     found_q;
  logic signed [WORD_W-1:0] lo_q;
  logic signed [WORD_W-1:0] hi_q;
  logic signed [WORD_W-1:0] top_q;
  logic [OUT_DATA_W-1:0]    out_q;

  logic full;
  logic do_write;

  assign full         = (count_q == CNT_W'(STACK_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.last  = (CNT_W'(idx_q) == count_q - CNT_W'(1));
  assign do_write     = cmd_i.update && (req_q == REQ_PUSH) && !full;
  assign out_data_o   = out_q;

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_type_i;
      value_q <= value_i;
      key_q   <= key_i;
    end
  end

  // Memory write on a push and registered read during the scan.
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[count_q[ADDR_W-1:0]] <= value_q;
    end
    if (cmd_i.scan_step) begin
      rd_q <= mem_q[idx_q];
    end
  end

  // Entry count and read-valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.update) begin
        if (req_q == REQ_PUSH && !full) begin
          count_q <= count_q + CNT_W'(1);
        end else if (req_q == REQ_POP && !stat_o.empty) begin
          count_q <= count_q - CNT_W'(1);
        end
      end
    end
  end

  // Status, scan index and running search, minimum, maximum and top.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      status_q <= STS_DONE;
      if (req_q == REQ_PUSH && full) begin
        status_q <= STS_FULL;
      end else if (req_q == REQ_POP && stat_o.empty) begin
        status_q <= STS_EMPTY;
      end
      idx_q   <= '0;
      found_q <= 1'b0;
      lo_q    <= INT_MAX;
      hi_q    <= INT_MIN;
      top_q   <= '0;
    end else begin
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + ADDR_W'(1);
      end
      if (rd_vld_q) begin
        // Entries are read bottom up, so the last one read is the top.
        top_q <= rd_q;
        if (rd_q == key_q) begin
          found_q <= 1'b1;
        end
        if (rd_q < lo_q) begin
          lo_q <= rd_q;
        end
        if (rd_q > hi_q) begin
          hi_q <= rd_q;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= {top_q, DEPTH_W'(count_q), hi_q, lo_q, found_q, status_q};
    end
  end

endmodule

// ----- design/stack_with_search_and_extremes_unit.sv -----
// Bounded LIFO stack of signed 32-bit words with a search and min/max scan.
// Each request pushes, pops or only inspects; afterwards every stored entry
// is read once, bottom to top, through the single read port of the stack
// memory, one entry per cycle. A new request is accepted only after the
// previous result has moved into the output register, and that move waits
// while an earlier result is still held there unaccepted. Exactly one result
// follows every request.
// A push on a full stack is refused with a full status and a pop on an empty
// stack with an empty status; an empty stack reports smallest 2147483647,
// largest -2147483648, found 0 and top 0. depth_used carries the low five
// bits of the count. Request code 3 behaves as an inspect.
module stack_with_search_and_extremes_unit #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: value [31:0], key [63:32]
  input  logic [swse_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: req_type [1:0]
  input  logic [swse_pkg::REQ_W-1:0]          s_axis_tuser,
  // Result channel.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: status [1:0], found [2], smallest [34:3], largest [66:35],
  //        depth_used [71:67], top_value [103:72]
  output logic [swse_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import swse_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencing of update, scan and result hand-over.
  swse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Stack memory, count and scan accumulators.
  swse_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .req_type_i (s_axis_tuser),
    .value_i    (s_axis_tdata[WORD_W-1:0]),
    .key_i      (s_axis_tdata[IN_DATA_W-1:WORD_W]),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ----- design/swse_checker.sv -----
module swse_checker #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [swse_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import swse_pkg::*;

  // The count is only fully visible while it fits the depth_used field.
  localparam bit CNT_VISIBLE = (STACK_DEPTH < 32);

  logic [STS_W-1:0]         sts;
  logic                     found;
  logic signed [WORD_W-1:0] lo;
  logic signed [WORD_W-1:0] hi;
  logic [DEPTH_W-1:0]       depth;
  logic signed [WORD_W-1:0] top;

  assign sts   = m_axis_tdata[OUT_STS_LSB +: STS_W];
  assign found = m_axis_tdata[OUT_FOUND_LSB];
  assign lo    = m_axis_tdata[OUT_LO_LSB +: WORD_W];
  assign hi    = m_axis_tdata[OUT_HI_LSB +: WORD_W];
  assign depth = m_axis_tdata[OUT_DEPTH_LSB +: DEPTH_W];
  assign top   = m_axis_tdata[OUT_TOP_LSB +: WORD_W];

  // A request that has just been taken keeps the input closed straight afterwards.
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after a request");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An empty stack reports the sentinels.
  a_empty_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_VISIBLE && m_axis_tvalid && depth == '0 |->
      !found && lo == INT_MAX && hi == INT_MIN && top == '0)
    else $error("empty stack reported wrong sentinels");

  // A non-empty stack has its top between the extremes.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_VISIBLE && m_axis_tvalid && depth != '0 |->
      lo <= hi && lo <= top && top <= hi)
    else $error("extremes inconsistent with top value");

  // Refusals agree with the reported count.
  a_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_VISIBLE && m_axis_tvalid && (sts == STS_FULL || sts == STS_EMPTY) |->
      (sts == STS_FULL && depth == DEPTH_W'(STACK_DEPTH)) ||
      (sts == STS_EMPTY && depth == '0))
    else $error("refusal status disagrees with count");

endmodule

bind stack_with_search_and_extremes_unit swse_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_swse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/tb_stack_with_search_and_extremes_unit.sv -----
module tb_stack_with_search_and_extremes_unit;
  import swse_pkg::*;

  localparam int unsigned STACK_DEPTH  = 16;
  localparam int          RANDOM_REQS  = 2000;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 30;
  localparam int          MAX_PRINTED  = 40;

  // One result as the block reports it, in the order of the master-side tdata.
  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic               found;
    logic [WORD_W-1:0]  smallest;
    logic [WORD_W-1:0]  largest;
    logic [DEPTH_W-1:0] depth_used;
    logic [WORD_W-1:0]  top_value;
  } stack_result_t;

  // One row of the directed table; a pinned row carries its result typed in.
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] key;
    logic              pinned;
    stack_result_t     result;
  } directed_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [REQ_W-1:0]      s_axis_tuser = REQ_INSPECT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow copy of the stack kept by the predictor.
  logic signed [WORD_W-1:0] model_words [STACK_DEPTH];
  int                       model_count = 0;

  stack_result_t expected_results [$];
  directed_row_t directed_rows [$];
  int            mismatches = 0;
  int            results_seen = 0;
  int            idle_cycles = 0;
  int            send_gap_max = 10;
  int            take_gap_max = 10;

  stack_with_search_and_extremes_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Applies one request to the shadow stack and works out the result it gives.
  task automatic stack_apply(input logic [REQ_W-1:0] req, input logic signed [WORD_W-1:0] value,
                             input logic signed [WORD_W-1:0] key, output stack_result_t res);
    logic signed [WORD_W-1:0] lo;
    logic signed [WORD_W-1:0] hi;
    res = '0;
    res.status = STS_DONE;
    if (req == REQ_PUSH) begin
      if (model_count >= STACK_DEPTH) begin
        res.status = STS_FULL;
      end else begin
        model_words[model_count] = value;
        model_count++;
      end
    end else if (req == REQ_POP) begin
      if (model_count == 0) begin
        res.status = STS_EMPTY;
      end else begin
        model_count--;
      end
    end
    lo = INT_MAX;
    hi = INT_MIN;
    for (int i = 0; i < model_count; i++) begin
      if (model_words[i] == key) res.found = 1'b1;
      if (model_words[i] < lo) lo = model_words[i];
      if (model_words[i] > hi) hi = model_words[i];
    end
    res.smallest   = lo;
    res.largest    = hi;
    res.depth_used = DEPTH_W'(model_count);
    res.top_value  = (model_count > 0) ? model_words[model_count - 1] : '0;
  endtask

  task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t: result %0d, %s: got %h, expected %h", $time, results_seen, field, got,
               want);
  endtask

  function automatic stack_result_t make_result(input logic [STS_W-1:0] status,
                                                input logic found,
                                                input logic [WORD_W-1:0] lo,
                                                input logic [WORD_W-1:0] hi,
                                                input logic [DEPTH_W-1:0] depth,
                                                input logic [WORD_W-1:0] top);
    stack_result_t res;
    res.status     = status;
    res.found      = found;
    res.smallest   = lo;
    res.largest    = hi;
    res.depth_used = depth;
    res.top_value  = top;
    return res;
  endfunction

  task automatic add_row(input logic [REQ_W-1:0] req, input logic [WORD_W-1:0] value,
                         input logic [WORD_W-1:0] key, input logic pinned,
                         input stack_result_t res);
    directed_row_t row;
    row.req    = req;
    row.value  = value;
    row.key    = key;
    row.pinned = pinned;
    row.result = res;
    directed_rows.push_back(row);
  endtask

  // Presents one request after a random gap and waits until it is taken.
  // The expected result is queued at the edge that accepts the request.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [WORD_W-1:0] value,
                              input logic [WORD_W-1:0] key, input logic pinned,
                              input stack_result_t pinned_res);
    int            gap;
    stack_result_t res;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {key, value};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    stack_apply(req, value, key, res);
    expected_results.push_back(pinned ? pinned_res : res);
  endtask

  // Withdraws the request line and waits until every result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, then compare each result with the oldest prediction.
  initial begin : result_side
    int            stall;
    stack_result_t got;
    stack_result_t want;
    forever begin
      if ($urandom_range(0, 39) == 0) take_gap_max = (take_gap_max == 0) ? 10 : 0;
      stall = $urandom_range(0, take_gap_max);
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && m_axis_tvalid));
      results_seen++;
      got.status     = m_axis_tdata[OUT_STS_LSB +: STS_W];
      got.found      = m_axis_tdata[OUT_FOUND_LSB];
      got.smallest   = m_axis_tdata[OUT_LO_LSB +: WORD_W];
      got.largest    = m_axis_tdata[OUT_HI_LSB +: WORD_W];
      got.depth_used = m_axis_tdata[OUT_DEPTH_LSB +: DEPTH_W];
      got.top_value  = m_axis_tdata[OUT_TOP_LSB +: WORD_W];
      if (expected_results.size() == 0) begin
        report_mismatch("no request outstanding", got.top_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status)
          report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
        if (got.found != want.found)
          report_mismatch("found", WORD_W'(got.found), WORD_W'(want.found));
        if (got.smallest != want.smallest)
          report_mismatch("smallest", got.smallest, want.smallest);
        if (got.largest != want.largest) report_mismatch("largest", got.largest, want.largest);
        if (got.depth_used != want.depth_used)
          report_mismatch("depth_used", WORD_W'(got.depth_used), WORD_W'(want.depth_used));
        if (got.top_value != want.top_value)
          report_mismatch("top_value", got.top_value, want.top_value);
      end
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    stack_result_t            none;
    stack_result_t            empty_res;
    logic [REQ_W-1:0]         req;
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] key;
    int                       pick;
    bit                       filling;

    none = '0;
    empty_res = make_result(STS_DONE, 1'b0, INT_MAX, INT_MIN, '0, '0);

    // Directed table: empty stack, extremes, every request code, full and empty refusals.
    add_row(REQ_POP, 32'd5, 32'd0, 1'b1,
            make_result(STS_EMPTY, 1'b0, INT_MAX, INT_MIN, '0, '0));
    add_row(REQ_INSPECT, 32'd0, 32'd0, 1'b1, empty_res);
    add_row(REQ_SPARE, 32'hFFFF_FFFF, INT_MIN, 1'b1, empty_res);
    add_row(REQ_PUSH, INT_MIN, INT_MIN, 1'b1,
            make_result(STS_DONE, 1'b1, INT_MIN, INT_MIN, 5'd1, INT_MIN));
    add_row(REQ_PUSH, INT_MAX, 32'd0, 1'b1,
            make_result(STS_DONE, 1'b0, INT_MIN, INT_MAX, 5'd2, INT_MAX));
    add_row(REQ_POP, 32'd0, INT_MAX, 1'b1,
            make_result(STS_DONE, 1'b0, INT_MIN, INT_MIN, 5'd1, INT_MIN));
    add_row(REQ_PUSH, INT_MAX, INT_MAX, 1'b0, none);
    add_row(REQ_PUSH, 32'd0, 32'hFFFF_FFFF, 1'b0, none);
    add_row(REQ_PUSH, 32'hFFFF_FFFF, 32'd0, 1'b0, none);
    add_row(REQ_PUSH, 32'd1, 32'd1, 1'b0, none);
    add_row(REQ_PUSH, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, none);
    add_row(REQ_PUSH, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, none);
    add_row(REQ_PUSH, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0, none);
    add_row(REQ_PUSH, 32'hFFFF_0000, 32'h0000_FFFF, 1'b0, none);
    add_row(REQ_PUSH, 32'd100, -32'sd100, 1'b0, none);
    add_row(REQ_PUSH, -32'sd100, 32'd100, 1'b0, none);
    add_row(REQ_PUSH, 32'h7FFF_FFFE, 32'h8000_0001, 1'b0, none);
    add_row(REQ_PUSH, 32'h8000_0001, 32'h7FFF_FFFE, 1'b0, none);
    add_row(REQ_PUSH, 32'd42, 32'd42, 1'b0, none);
    add_row(REQ_PUSH, 32'd42, 32'd43, 1'b0, none);
    add_row(REQ_PUSH, 32'h1234_5678, 32'd0, 1'b0, none);
    add_row(REQ_PUSH, 32'd7, INT_MAX, 1'b1,
            make_result(STS_FULL, 1'b1, INT_MIN, INT_MAX, 5'd16, 32'h1234_5678));
    add_row(REQ_SPARE, 32'd0, 32'hAAAA_AAAA, 1'b0, none);
    add_row(REQ_POP, 32'd0, 32'h1234_5678, 1'b0, none);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].value, directed_rows[i].key,
                   directed_rows[i].pinned, directed_rows[i].result);
    drain_results();

    // Random part: the stack swings between empty and full, so refusals at both
    // ends and scans of every depth come up again and again.
    filling = 1'b1;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if ($urandom_range(0, 49) == 0) send_gap_max = (send_gap_max == 0) ? 10 : 0;
      if (model_count == STACK_DEPTH && $urandom_range(0, 1) == 0) filling = 1'b0;
      if (model_count == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;
      if ($urandom_range(0, 59) == 0) filling = ~filling;

      pick = $urandom_range(0, 99);
      if (pick < 65)      req = filling ? REQ_PUSH : REQ_POP;
      else if (pick < 80) req = filling ? REQ_POP : REQ_PUSH;
      else if (pick < 95) req = REQ_INSPECT;
      else                req = REQ_SPARE;

      case ($urandom_range(0, 9))
        0:       value = INT_MIN;
        1:       value = INT_MAX;
        2, 3:    value = $signed($urandom_range(0, 16)) - 8;
        default: value = $urandom;
      endcase

      pick = $urandom_range(0, 9);
      if (pick < 5 && model_count > 0)
        key = model_words[$urandom_range(0, model_count - 1)];
      else if (pick < 7)
        key = value;
      else if (pick < 8)
        key = $signed($urandom_range(0, 16)) - 8;
      else
        key = $urandom;

      send_request(req, value, key, 1'b0, none);
      if (n % 400 == 399) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/swse_pkg.sv
design/swse_ctrl.sv
design/swse_dpath.sv
design/stack_with_search_and_extremes_unit.sv
design/swse_checker.sv
bench/tb_stack_with_search_and_extremes_unit.sv
